FILE: design/pfe_pkg.sv
// Shared types and constants for the postfix expression evaluator.
// Used by pfe_front, pfe_fifo, pfe_back and the top level; no dependencies.
`default_nettype none

package pfe_pkg;

  localparam int SYMBOL_W            = 8;
  localparam int WORD_W              = 32;
  localparam int DIGIT_W             = 4;
  localparam int STATUS_W            = 2;
  localparam int OUT_TDATA_W         = 40;
  localparam int DEFAULT_STACK_DEPTH = 16;
  localparam int QUEUE_DEPTH         = 4;
  localparam int DIV_STEP_W          = 5;

  // ASCII codes that mean something
  localparam logic [SYMBOL_W-1:0] CH_TERM  = 8'h00;
  localparam logic [SYMBOL_W-1:0] CH_ZERO  = 8'h30;
  localparam logic [SYMBOL_W-1:0] CH_NINE  = 8'h39;
  localparam logic [SYMBOL_W-1:0] CH_PLUS  = 8'h2B;
  localparam logic [SYMBOL_W-1:0] CH_MINUS = 8'h2D;
  localparam logic [SYMBOL_W-1:0] CH_STAR  = 8'h2A;
  localparam logic [SYMBOL_W-1:0] CH_SLASH = 8'h2F;
  localparam logic [SYMBOL_W-1:0] CH_PCT   = 8'h25;
  localparam logic [SYMBOL_W-1:0] CH_CARET = 8'h5E;

  // Result status codes
  localparam logic [STATUS_W-1:0] STATUS_OK      = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_DIV_ZERO = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_MOD_ZERO = 2'd2;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_DIGIT,
    OP_ADD,
    OP_SUB,
    OP_MUL,
    OP_DIV,
    OP_MOD,
    OP_POW,
    OP_TERM
  } op_t;

  // One classified item as it travels through the queue
  typedef struct packed {
    op_t                op;
    logic [DIGIT_W-1:0] digit;
  } queue_item_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_POPB,
    S_POPA,
    S_LOADA,
    S_CALC,
    S_DIV,
    S_DFIN,
    S_POW,
    S_PUSH,
    S_EMIT
  } state_t;

endpackage

`default_nettype wire

FILE: design/postfix_expression_evaluator.sv
// Postfix expression evaluator: a character is taken each cycle the queue has room
// (4 items); the stack engine behind the queue works one item at a time. A digit is pushed
// on intake; + - * pop both operands and push the result, / and % run a 32-step restoring
// divider (skipped on a zero divisor), ^ squares and multiplies per exponent bit on one
// shared 32x32 multiplier, and the terminator pops the result (unless an error is set) and
// may wait for the result slot. Ignored characters cost no engine time. The stack is a
// 32-bit memory of STACK_DEPTH words with a registered read, so each pop has a state of its
// own. Depends on pfe_pkg, pfe_front, pfe_fifo, pfe_back.
`default_nettype none

module postfix_expression_evaluator #(
  parameter int STACK_DEPTH = pfe_pkg::DEFAULT_STACK_DEPTH
) (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           s_tvalid,
  output logic                                s_tready,
  input  wire logic [pfe_pkg::SYMBOL_W-1:0]   s_tdata,   // [7:0] symbol
  output logic                                m_tvalid,
  input  wire logic                           m_tready,
  // [31:0] result_value, [33:32] status, [34] overflow_seen,
  // [35] underflow_seen, [39:36] zero
  output logic [pfe_pkg::OUT_TDATA_W-1:0]     m_tdata
);
  import pfe_pkg::*;

  logic        fq_valid;
  logic        fq_ready;
  queue_item_t fq_item;
  logic        qb_valid;
  logic        qb_ready;
  queue_item_t qb_item;

  // Decode incoming symbols
  pfe_front u_front (
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .q_valid  (fq_valid),
    .q_ready  (fq_ready),
    .q_item   (fq_item)
  );

  // Decouple decode from the stack engine
  pfe_fifo u_fifo (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (fq_valid),
    .in_ready  (fq_ready),
    .in_item   (fq_item),
    .out_valid (qb_valid),
    .out_ready (qb_ready),
    .out_item  (qb_item)
  );

  // Stack engine and result register
  pfe_back #(
    .STACK_DEPTH (STACK_DEPTH)
  ) u_back (
    .clk      (clk),
    .rst      (rst),
    .q_valid  (qb_valid),
    .q_ready  (qb_ready),
    .q_item   (qb_item),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

endmodule

`default_nettype wire

FILE: design/pfe_front.sv
// Front end: accepts input symbols and classifies them into queue items.
// Depends on pfe_pkg. Characters with no meaning are accepted and dropped here.
`default_nettype none

module pfe_front (
  input  wire logic                         s_tvalid,
  output logic                              s_tready,
  input  wire logic [pfe_pkg::SYMBOL_W-1:0] s_tdata,   // [7:0] symbol
  output logic                              q_valid,
  input  wire logic                         q_ready,
  output pfe_pkg::queue_item_t              q_item
);
  import pfe_pkg::*;

  op_t                op;
  logic [SYMBOL_W-1:0] digit_off;

  // Symbol decoder
  always_comb begin
    digit_off = s_tdata - CH_ZERO;
    if (s_tdata >= CH_ZERO && s_tdata <= CH_NINE) begin
      op = OP_DIGIT;
    end else begin
      unique case (s_tdata)
        CH_TERM:  op = OP_TERM;
        CH_PLUS:  op = OP_ADD;
        CH_MINUS: op = OP_SUB;
        CH_STAR:  op = OP_MUL;
        CH_SLASH: op = OP_DIV;
        CH_PCT:   op = OP_MOD;
        CH_CARET: op = OP_POW;
        default:  op = OP_NONE;
      endcase
    end
  end

  // Ignored characters never reach the queue
  assign q_item.op    = op;
  assign q_item.digit = digit_off[DIGIT_W-1:0];
  assign q_valid      = s_tvalid && (op != OP_NONE);
  assign s_tready     = q_ready;

endmodule

`default_nettype wire

FILE: design/pfe_fifo.sv
// Short queue of classified items between the front end and the stack engine.
// Depends on pfe_pkg for the item type and depth.
`default_nettype none

module pfe_fifo (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 in_valid,
  output logic                      in_ready,
  input  wire pfe_pkg::queue_item_t in_item,
  output logic                      out_valid,
  input  wire logic                 out_ready,
  output pfe_pkg::queue_item_t      out_item
);
  import pfe_pkg::*;

  localparam int PW = $clog2(QUEUE_DEPTH);
  localparam int CW = $clog2(QUEUE_DEPTH + 1);

  queue_item_t     slots [QUEUE_DEPTH];
  logic [PW-1:0]   wr_ptr;
  logic [PW-1:0]   rd_ptr;
  logic [CW-1:0]   count;
  logic            wr_fire;
  logic            rd_fire;

  assign in_ready  = (count != CW'(QUEUE_DEPTH));
  assign out_valid = (count != '0);
  assign out_item  = slots[rd_ptr];
  assign wr_fire   = in_valid && in_ready;
  assign rd_fire   = out_valid && out_ready;

  // Storage
  always_ff @(posedge clk) begin
    if (wr_fire) begin
      slots[wr_ptr] <= in_item;
    end
  end

  // Pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (wr_fire) begin
        wr_ptr <= wr_ptr + PW'(1);
      end
      if (rd_fire) begin
        rd_ptr <= rd_ptr + PW'(1);
      end
      if (wr_fire && !rd_fire) begin
        count <= count + CW'(1);
      end else if (rd_fire && !wr_fire) begin
        count <= count - CW'(1);
      end
    end
  end

endmodule

`default_nettype wire

FILE: design/pfe_back.sv
// Stack engine: operand stack memory, shared multiplier, iterative divider
// and power loop, result register. Depends on pfe_pkg.
`default_nettype none

module pfe_back #(
  parameter int STACK_DEPTH = pfe_pkg::DEFAULT_STACK_DEPTH
) (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            q_valid,
  output logic                                 q_ready,
  input  wire pfe_pkg::queue_item_t            q_item,
  output logic                                 m_tvalid,
  input  wire logic                            m_tready,
  output logic [pfe_pkg::OUT_TDATA_W-1:0]      m_tdata
);
  import pfe_pkg::*;

  localparam int AW = $clog2(STACK_DEPTH);
  localparam int CW = $clog2(STACK_DEPTH + 1);

  state_t               state;
  state_t               state_next;
  op_t                  op;
  logic [CW-1:0]        cnt;
  logic [CW-1:0]        cnt_m1;
  logic [STATUS_W-1:0]  err;
  logic                 ovf;
  logic                 unf;
  logic                 rd_ok;
  logic                 phase;

  logic [WORD_W-1:0]    a;      // left operand, base / square in power loop
  logic [WORD_W-1:0]    b;      // right operand, exponent in power loop
  logic [WORD_W-1:0]    res;    // result to push, accumulator in power loop
  logic [WORD_W-1:0]    dq;     // dividend magnitude shifting into quotient
  logic [WORD_W-1:0]    dr;     // partial remainder
  logic [WORD_W-1:0]    dvs;    // divisor magnitude
  logic [DIV_STEP_W-1:0] dstep;

  logic [WORD_W-1:0]    mem [STACK_DEPTH];
  logic [WORD_W-1:0]    rd_data;
  logic [WORD_W-1:0]    popped;

  logic                 q_take;
  logic                 mem_we;
  logic [WORD_W-1:0]    mem_wdata;
  logic                 rd_en;
  logic                 out_load;
  logic                 out_free;
  logic                 stack_full;

  logic [WORD_W-1:0]    mul_x;
  logic [WORD_W-1:0]    mul_y;
  logic [WORD_W-1:0]    mul_p;
  logic [WORD_W:0]      rem_sh;
  logic [WORD_W:0]      rem_sub;
  logic [WORD_W-1:0]    pow_neg;

  assign cnt_m1     = cnt - CW'(1);
  assign stack_full = (cnt >= CW'(STACK_DEPTH));
  assign out_free   = !m_tvalid || m_tready;
  assign popped     = rd_ok ? rd_data : '0;

  // Shared multiplier: a*b for '*', acc*sq then sq*sq in the power loop
  assign mul_x = (state == S_POW && !phase) ? res : a;
  assign mul_y = (state == S_POW) ? a : b;
  assign mul_p = mul_x * mul_y;

  // Restoring divider step
  assign rem_sh  = {dr, dq[WORD_W-1]};
  assign rem_sub = rem_sh - {1'b0, dvs};

  // Power with a negative exponent
  always_comb begin
    if (a == WORD_W'(1)) begin
      pow_neg = WORD_W'(1);
    end else if (a == '1) begin
      pow_neg = b[0] ? '1 : WORD_W'(1);
    end else begin
      pow_neg = '0;
    end
  end

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (q_valid) begin
          if (q_item.op == OP_TERM) begin
            state_next = (err != STATUS_OK) ? S_EMIT : S_POPB;
          end else if (err == STATUS_OK && q_item.op != OP_DIGIT &&
                       q_item.op != OP_NONE) begin
            state_next = S_POPB;
          end
        end
      end
      S_POPB:  state_next = (op == OP_TERM) ? S_EMIT : S_POPA;
      S_POPA:  state_next = S_LOADA;
      S_LOADA: state_next = S_CALC;
      S_CALC: begin
        if (op == OP_DIV || op == OP_MOD) begin
          state_next = (b == '0) ? S_IDLE : S_DIV;
        end else if (op == OP_POW) begin
          state_next = b[WORD_W-1] ? S_PUSH : S_POW;
        end else begin
          state_next = S_PUSH;
        end
      end
      S_DIV:   state_next = (dstep == '1) ? S_DFIN : S_DIV;
      S_DFIN:  state_next = S_PUSH;
      S_POW:   state_next = (b == '0) ? S_PUSH : S_POW;
      S_PUSH:  state_next = S_IDLE;
      S_EMIT:  state_next = out_free ? S_IDLE : S_EMIT;
      default: state_next = S_IDLE;
    endcase
  end

  // Control outputs
  always_comb begin
    q_take    = 1'b0;
    mem_we    = 1'b0;
    mem_wdata = res;
    rd_en     = 1'b0;
    out_load  = 1'b0;
    unique case (state)
      S_IDLE: begin
        q_take    = q_valid;
        mem_wdata = WORD_W'(q_item.digit);
        mem_we    = q_valid && q_item.op == OP_DIGIT && err == STATUS_OK && !stack_full;
      end
      S_POPB, S_POPA: rd_en = (cnt != '0);
      S_PUSH:         mem_we = !stack_full;
      S_EMIT:         out_load = out_free;
      default: begin
      end
    endcase
  end

  assign q_ready = q_take;

  // Stack memory, registered read
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[cnt[AW-1:0]] <= mem_wdata;
    end
    if (rd_en) begin
      rd_data <= mem[cnt_m1[AW-1:0]];
    end
  end

  // Control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      cnt      <= '0;
      err      <= STATUS_OK;
      ovf      <= 1'b0;
      unf      <= 1'b0;
      rd_ok    <= 1'b0;
      phase    <= 1'b0;
      dstep    <= '0;
      m_tvalid <= 1'b0;
    end else begin
      state <= state_next;
      if (mem_we) begin
        cnt <= cnt + CW'(1);
      end
      // pushes in idle and push state drop on a full stack
      if ((state == S_PUSH || (state == S_IDLE && q_valid && q_item.op == OP_DIGIT &&
           err == STATUS_OK)) && stack_full) begin
        ovf <= 1'b1;
      end
      if (state == S_POPB || state == S_POPA) begin
        rd_ok <= (cnt != '0);
        if (cnt != '0) begin
          cnt <= cnt_m1;
        end else begin
          unf <= 1'b1;
        end
      end
      if (state == S_CALC && b == '0) begin
        if (op == OP_DIV) begin
          err <= STATUS_DIV_ZERO;
        end else if (op == OP_MOD) begin
          err <= STATUS_MOD_ZERO;
        end
      end
      if (state == S_CALC) begin
        phase <= 1'b0;
        dstep <= '0;
      end
      if (state == S_POW) begin
        phase <= !phase;
      end
      if (state == S_DIV) begin
        dstep <= dstep + DIV_STEP_W'(1);
      end
      // expression done: clear the stack and sticky flags
      if (out_load) begin
        cnt <= '0;
        err <= STATUS_OK;
        ovf <= 1'b0;
        unf <= 1'b0;
      end
      if (out_load) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    if (q_take) begin
      op <= q_item.op;
    end
    case (state)
      S_POPA:  b <= popped;
      S_LOADA: a <= popped;
      S_CALC: begin
        dq  <= a[WORD_W-1] ? -a : a;
        dvs <= b[WORD_W-1] ? -b : b;
        dr  <= '0;
        case (op)
          OP_ADD:  res <= a + b;
          OP_SUB:  res <= a - b;
          OP_MUL:  res <= mul_p;
          OP_POW:  res <= b[WORD_W-1] ? pow_neg : WORD_W'(1);
          default: res <= '0;
        endcase
      end
      S_DIV: begin
        if (!rem_sub[WORD_W]) begin
          dr <= rem_sub[WORD_W-1:0];
          dq <= {dq[WORD_W-2:0], 1'b1};
        end else begin
          dr <= rem_sh[WORD_W-1:0];
          dq <= {dq[WORD_W-2:0], 1'b0};
        end
      end
      S_DFIN: begin
        if (op == OP_DIV) begin
          res <= (a[WORD_W-1] ^ b[WORD_W-1]) ? -dq : dq;
        end else begin
          res <= a[WORD_W-1] ? -dr : dr;
        end
      end
      S_POW: begin
        if (b != '0) begin
          if (!phase) begin
            if (b[0]) begin
              res <= mul_p;
            end
          end else begin
            a <= mul_p;
            b <= b >> 1;
          end
        end
      end
      default: begin
      end
    endcase
    if (out_load) begin
      m_tdata <= {4'b0000, unf, ovf, err,
                  (err != STATUS_OK) ? {WORD_W{1'b1}} : popped};
    end
  end

`ifndef ASSERT_OFF
  a_cnt_bound: assert property (@(posedge clk) disable iff (rst)
    cnt <= CW'(STACK_DEPTH))
    else $error("stack count beyond depth");
  a_no_push_full: assert property (@(posedge clk) disable iff (rst)
    mem_we |-> !stack_full)
    else $error("write into a full stack");
  a_clear_after_emit: assert property (@(posedge clk) disable iff (rst)
    out_load |=> (cnt == '0 && err == STATUS_OK && !ovf && !unf && m_tvalid))
    else $error("state not cleared after result");
  a_div_nonzero: assert property (@(posedge clk) disable iff (rst)
    (state == S_DIV) |-> (dvs != '0 && err == STATUS_OK))
    else $error("divider running on zero divisor");
`endif

endmodule

`default_nettype wire
